@@ rtl/core/tpad_pkg.sv @@
// Shared types, codes and constants of the three point angle core.
`default_nettype none

package tpad_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_MISSING   = 2'd1,
        STATUS_BOTH_ZERO = 2'd2,
        STATUS_ONE_ZERO  = 2'd3
    } status_t;

    // Angle presentation modes.
    localparam logic [1:0] MODE_MINIMAL  = 2'd0;
    localparam logic [1:0] MODE_POSITIVE = 2'd1;
    localparam logic [1:0] MODE_SIGNED   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_AXIS_X = 2'd1;
    localparam logic [1:0] REG_AXIS_Y = 2'd2;
    localparam logic [1:0] REG_AXIS_Z = 2'd3;

    // Port widths fixed by the item format.
    localparam int PORT_W   = 32;
    localparam int ANGLE_W  = 18;

    // Datapath widths.
    localparam int SC_W     = 31;  // scaled leg component, magnitude below 2^30
    localparam int PR_W     = 62;  // product of two scaled components
    localparam int DOT_W    = 64;  // sum of three products
    localparam int CP_W     = 63;  // difference of two products
    localparam int CX_W     = 32;  // cross component after the shift by 30
    localparam int C_W      = 33;  // cosine term after the shift by 30
    localparam int SQ_W     = 63;  // square of a cross component
    localparam int Q_W      = 64;  // squared cross length
    localparam int ROOT_W   = 32;  // its square root
    localparam int SHIFT30  = 30;
    localparam int NORM_HI  = 30;  // scaled legs land in [2^29, 2^30)
    localparam int NORM_LO  = 29;

    // Rotation unit.
    localparam int CORDIC_STEPS = 23;
    localparam int CORDIC_W     = 36;
    localparam int ACC_FRAC     = 16;
    localparam int ACC_W        = 26;
    localparam int RES_W        = 27;
    localparam logic signed [ACC_W-1:0] ACC_QUARTER = ACC_W'(90) <<< ACC_FRAC;
    localparam logic signed [ACC_W-1:0] ACC_HALF    = ACC_W'(180) <<< ACC_FRAC;

    // atan(2^-i) in degrees, 16 fraction bits.
    localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
        26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334,
        26'sd3667, 26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115,
        26'sd57, 26'sd29, 26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1
    };

    // Pipeline depths.
    localparam int FRONT_LAT  = 8;
    localparam int SQRT_LAT   = ROOT_W;
    localparam int CORDIC_LAT = CORDIC_STEPS + 1;
    localparam int TOTAL_LAT  = FRONT_LAT + SQRT_LAT + CORDIC_LAT + 1;

    // Control that travels beside the data.
    typedef struct packed {
        logic    valid;
        status_t status;
        logic    neg;
    } meta_t;

    // Shift right with truncation toward zero.
    function automatic logic signed [CORDIC_W-1:0] cordic_shr(
        input logic signed [CORDIC_W-1:0] v,
        input int k
    );
        logic [CORDIC_W-1:0] m;
        m = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
        m = m >> k;
        return v[CORDIC_W-1] ? CORDIC_W'(-m) : m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/tpad_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module tpad_isqrt (
    input  wire logic                        clk,
    input  wire logic [tpad_pkg::Q_W-1:0]    q,
    output logic      [tpad_pkg::ROOT_W-1:0] root
);
    import tpad_pkg::*;

    localparam int TR_W = Q_W + 2;

    logic [Q_W-1:0]    rem_reg  [SQRT_LAT];
    logic [ROOT_W-1:0] root_reg [SQRT_LAT];
    logic [Q_W-1:0]    rem_in   [SQRT_LAT];
    logic [ROOT_W-1:0] root_in  [SQRT_LAT];
    logic [TR_W-1:0]   trial_c  [SQRT_LAT];
    logic              take_c   [SQRT_LAT];

    // Stage k decides root bit ROOT_W-1-k against the running remainder.
    always_comb
    begin
        for (int k = 0; k < SQRT_LAT; k++)
        begin
            rem_in[k]  = (k == 0) ? q : rem_reg[(k == 0) ? 0 : k - 1];
            root_in[k] = (k == 0) ? '0 : root_reg[(k == 0) ? 0 : k - 1];
            trial_c[k] = (TR_W'(root_in[k]) << (ROOT_W - k))
                       | (TR_W'(1) << (2 * (ROOT_W - 1 - k)));
            take_c[k]  = TR_W'(rem_in[k]) >= trial_c[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQRT_LAT; k++)
        begin
            if (take_c[k])
            begin
                rem_reg[k]  <= rem_in[k] - trial_c[k][Q_W-1:0];
                root_reg[k] <= root_in[k] | (ROOT_W'(1) << (ROOT_W - 1 - k));
            end
            else
            begin
                rem_reg[k]  <= rem_in[k];
                root_reg[k] <= root_in[k];
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

`default_nettype wire

@@ rtl/core/tpad_cordic.sv @@
// Pipelined vectoring rotation giving atan2(s, c) in degrees for s >= 0.
`default_nettype none

module tpad_cordic (
    input  wire logic                                clk,
    input  wire logic signed [tpad_pkg::C_W-1:0]     c,
    input  wire logic        [tpad_pkg::ROOT_W-1:0]  s,
    output logic      signed [tpad_pkg::ACC_W-1:0]   acc
);
    import tpad_pkg::*;

    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [ACC_W-1:0]    z_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] x0;
    logic signed [CORDIC_W-1:0] y0;

    assign x0 = CORDIC_W'(c);
    assign y0 = $signed(CORDIC_W'(s));

    // A negative cosine is rotated by 90 degrees first, then the
    // micro-rotations drive y toward zero.
    always_ff @(posedge clk)
    begin
        if (x0 < 0)
        begin
            x_reg[0] <= y0;
            y_reg[0] <= -x0;
            z_reg[0] <= ACC_QUARTER;
        end
        else
        begin
            x_reg[0] <= x0;
            y_reg[0] <= y0;
            z_reg[0] <= '0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (y_reg[i] > 0)
            begin
                x_reg[i+1] <= x_reg[i] + cordic_shr(y_reg[i], i);
                y_reg[i+1] <= y_reg[i] - cordic_shr(x_reg[i], i);
                z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - cordic_shr(y_reg[i], i);
                y_reg[i+1] <= y_reg[i] + cordic_shr(x_reg[i], i);
                z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
            end
        end
    end

    assign acc = z_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

@@ rtl/core/three_point_angle_degrees_core.sv @@
// Top level of the three point angle core: leg setup, scaling, products, square root, rotation and output.
`default_nettype none

// The core takes one item per clock and never asserts busy. Each item gives
// exactly one result, shown on angle and status with done high for one
// cycle, after 8 stages of leg setup, scaling and products, 32 stages of
// square root (one root bit each) and 24 stages of rotation, then the
// output register. The receiver cannot stall, so results must be taken as
// they appear. Registers may be written only while no item is in flight.
module three_point_angle_degrees_core #(
    parameter int COORD_WIDTH     = 32,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                points_defined,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  first_x,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  first_y,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  first_z,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  center_x,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  center_y,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  center_z,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  second_x,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  second_y,
    input  wire logic signed [tpad_pkg::PORT_W-1:0]  second_z,
    input  wire logic                                cfg_write,
    input  wire logic [1:0]                          cfg_index,
    input  wire logic [tpad_pkg::PORT_W-1:0]         cfg_data,
    output logic                                     done,
    output logic signed [tpad_pkg::ANGLE_W-1:0]      angle,
    output logic [1:0]                               status
);
    import tpad_pkg::*;

    localparam int LW    = (COORD_WIDTH > PORT_W) ? PORT_W : COORD_WIDTH;
    localparam int LEG_W = LW + 1;
    localparam int PW    = $clog2(LEG_W);
    localparam int CR_W  = 2 * LEG_W + 1;
    localparam int LO_W  = CR_W / 2;
    localparam int HI_W  = CR_W - LO_W;
    localparam int T_W   = CR_W + 34;
    localparam int RSH   = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int MP_LEN = FRONT_LAT - 1 + SQRT_LAT + CORDIC_LAT;
    localparam int NEG_AT = 4;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'((1 << RSH) >> 1);
    localparam logic signed [RES_W-1:0] FULL_TURN = RES_W'(360) <<< ANGLE_FRAC_BITS;
    localparam logic signed [RES_W-1:0] RIGHT_ANGLE = RES_W'(90) <<< ANGLE_FRAC_BITS;

    // Configuration registers.
    logic [1:0]               mode_reg;
    logic signed [PORT_W-1:0] axis_reg [3];

    // Stage registers.
    logic                     valid1_reg;
    logic                     def1_reg;
    logic signed [LEG_W-1:0]  a1_reg [3];
    logic signed [LEG_W-1:0]  b1_reg [3];
    logic signed [LEG_W-1:0]  a2_reg [3];
    logic signed [LEG_W-1:0]  b2_reg [3];
    logic [LEG_W-1:0]         ma2_reg;
    logic [LEG_W-1:0]         mb2_reg;
    logic signed [2*LEG_W-1:0] cp2_reg [6];
    logic signed [LEG_W-1:0]  a3_reg [3];
    logic signed [LEG_W-1:0]  b3_reg [3];
    logic [PW-1:0]            pa3_reg;
    logic [PW-1:0]            pb3_reg;
    logic signed [CR_W-1:0]   cr3_reg [3];
    logic signed [SC_W-1:0]   sa4_reg [3];
    logic signed [SC_W-1:0]   sb4_reg [3];
    logic signed [HI_W+PORT_W-1:0]   hn4_reg [3];
    logic signed [LO_W+PORT_W:0]     ln4_reg [3];
    logic signed [PR_W-1:0]   pr5_reg [9];
    logic signed [T_W-1:0]    tc5_reg [3];
    logic signed [C_W-1:0]    c6_reg;
    logic signed [CX_W-1:0]   cx6_reg [3];
    logic signed [C_W-1:0]    c7_reg;
    logic [SQ_W-1:0]          sq7_reg [3];
    logic signed [C_W-1:0]    c8_reg;
    logic [Q_W-1:0]           q8_reg;
    logic signed [C_W-1:0]    cdly_reg [SQRT_LAT];
    meta_t                    mpipe_reg [MP_LEN];
    logic                     done_reg;
    logic signed [ANGLE_W-1:0] angle_reg;
    status_t                  status_reg;

    // Combinational signals.
    logic                     accept;
    logic signed [LEG_W-1:0]  fp_c [3];
    logic signed [LEG_W-1:0]  cp_c [3];
    logic signed [LEG_W-1:0]  sp_c [3];
    logic [LEG_W-1:0]         mag_a_c [3];
    logic [LEG_W-1:0]         mag_b_c [3];
    logic [LEG_W-1:0]         ma_c;
    logic [LEG_W-1:0]         mb_c;
    logic                     za_c;
    logic                     zb_c;
    meta_t                    meta2_c;
    meta_t                    mneg_c;
    logic [PW-1:0]            pa_c;
    logic [PW-1:0]            pb_c;
    logic signed [T_W-1:0]    tsum_c;
    logic signed [DOT_W-1:0]  dot_c;
    logic [DOT_W-1:0]         dmag_c;
    logic [C_W-1:0]           dsh_c;
    logic signed [CP_W-1:0]   crs_c [3];
    logic [CP_W-1:0]          cmag_c [3];
    logic [CX_W-1:0]          csh_c [3];
    logic signed [2*CX_W-1:0] sq_c [3];
    logic [ROOT_W-1:0]        root;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  clamp_c;
    logic signed [ACC_W-1:0]  base_c;
    logic signed [RES_W-1:0]  res_c;
    meta_t                    mout_c;

    // Scale one leg component so the largest lands in [2^29, 2^30).
    function automatic logic signed [SC_W-1:0] scale_comp(
        input logic signed [LEG_W-1:0] v,
        input logic [PW-1:0]           p
    );
        logic [LEG_W-1:0] m;
        logic [LEG_W-1:0] r;
        m = v[LEG_W-1] ? LEG_W'(-v) : LEG_W'(v);
        r = '0;
        if (int'(p) >= NORM_HI)
        begin
            r = m >> (int'(p) - NORM_LO);
            scale_comp = v[LEG_W-1] ? -$signed(SC_W'(r)) : $signed(SC_W'(r));
        end
        else
        begin
            scale_comp = SC_W'(v) <<< (NORM_LO - int'(p));
        end
    endfunction

    // The core is always ready for the next item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_MINIMAL;
            axis_reg[0] <= '0;
            axis_reg[1] <= '0;
            axis_reg[2] <= PORT_W'(65536);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MODE:   mode_reg    <= cfg_data[1:0];
                REG_AXIS_X: axis_reg[0] <= cfg_data;
                REG_AXIS_Y: axis_reg[1] <= cfg_data;
                REG_AXIS_Z: axis_reg[2] <= cfg_data;
                default:    mode_reg    <= mode_reg;
            endcase
        end
    end

    // Stage 1: legs from the low coordinate bits.
    assign fp_c[0] = LEG_W'($signed(first_x[LW-1:0]));
    assign fp_c[1] = LEG_W'($signed(first_y[LW-1:0]));
    assign fp_c[2] = LEG_W'($signed(first_z[LW-1:0]));
    assign cp_c[0] = LEG_W'($signed(center_x[LW-1:0]));
    assign cp_c[1] = LEG_W'($signed(center_y[LW-1:0]));
    assign cp_c[2] = LEG_W'($signed(center_z[LW-1:0]));
    assign sp_c[0] = LEG_W'($signed(second_x[LW-1:0]));
    assign sp_c[1] = LEG_W'($signed(second_y[LW-1:0]));
    assign sp_c[2] = LEG_W'($signed(second_z[LW-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        def1_reg <= points_defined;
        for (int i = 0; i < 3; i++)
        begin
            a1_reg[i] <= fp_c[i] - cp_c[i];
            b1_reg[i] <= sp_c[i] - cp_c[i];
        end
    end

    // Stage 2: magnitudes, zero tests, status and cross products of the raw legs.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_a_c[i] = a1_reg[i][LEG_W-1] ? LEG_W'(-a1_reg[i]) : LEG_W'(a1_reg[i]);
            mag_b_c[i] = b1_reg[i][LEG_W-1] ? LEG_W'(-b1_reg[i]) : LEG_W'(b1_reg[i]);
        end
        ma_c = mag_a_c[0];
        mb_c = mag_b_c[0];
        for (int i = 1; i < 3; i++)
        begin
            if (mag_a_c[i] > ma_c)
            begin
                ma_c = mag_a_c[i];
            end
            if (mag_b_c[i] > mb_c)
            begin
                mb_c = mag_b_c[i];
            end
        end
        za_c = (ma_c == '0);
        zb_c = (mb_c == '0);
        meta2_c.valid = valid1_reg;
        meta2_c.neg   = 1'b0;
        priority if (!def1_reg)
        begin
            meta2_c.status = STATUS_MISSING;
        end
        else if (za_c && zb_c)
        begin
            meta2_c.status = STATUS_BOTH_ZERO;
        end
        else if (za_c || zb_c)
        begin
            meta2_c.status = STATUS_ONE_ZERO;
        end
        else
        begin
            meta2_c.status = STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        ma2_reg    <= ma_c;
        mb2_reg    <= mb_c;
        for (int i = 0; i < 3; i++)
        begin
            a2_reg[i] <= a1_reg[i];
            b2_reg[i] <= b1_reg[i];
        end
        cp2_reg[0] <= a1_reg[1] * b1_reg[2];
        cp2_reg[1] <= a1_reg[2] * b1_reg[1];
        cp2_reg[2] <= a1_reg[2] * b1_reg[0];
        cp2_reg[3] <= a1_reg[0] * b1_reg[2];
        cp2_reg[4] <= a1_reg[0] * b1_reg[1];
        cp2_reg[5] <= a1_reg[1] * b1_reg[0];
    end

    // Stage 3: leading one of each leg's largest magnitude; exact cross product.
    always_comb
    begin
        pa_c = '0;
        pb_c = '0;
        for (int j = 0; j < LEG_W; j++)
        begin
            if (ma2_reg[j])
            begin
                pa_c = PW'(j);
            end
            if (mb2_reg[j])
            begin
                pb_c = PW'(j);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pa3_reg <= pa_c;
        pb3_reg <= pb_c;
        for (int i = 0; i < 3; i++)
        begin
            a3_reg[i]  <= a2_reg[i];
            b3_reg[i]  <= b2_reg[i];
            cr3_reg[i] <= CR_W'(cp2_reg[2*i]) - CR_W'(cp2_reg[2*i+1]);
        end
    end

    // Stage 4: scaled legs; cross product halves times the axis.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sa4_reg[i] <= scale_comp(a3_reg[i], pa3_reg);
            sb4_reg[i] <= scale_comp(b3_reg[i], pb3_reg);
            hn4_reg[i] <= $signed(cr3_reg[i][CR_W-1:LO_W]) * axis_reg[i];
            ln4_reg[i] <= $signed({1'b0, cr3_reg[i][LO_W-1:0]}) * axis_reg[i];
        end
    end

    // Stage 5: products of the scaled legs; rejoin the triple product terms.
    always_ff @(posedge clk)
    begin
        pr5_reg[0] <= sa4_reg[0] * sb4_reg[0];
        pr5_reg[1] <= sa4_reg[1] * sb4_reg[1];
        pr5_reg[2] <= sa4_reg[2] * sb4_reg[2];
        pr5_reg[3] <= sa4_reg[1] * sb4_reg[2];
        pr5_reg[4] <= sa4_reg[2] * sb4_reg[1];
        pr5_reg[5] <= sa4_reg[2] * sb4_reg[0];
        pr5_reg[6] <= sa4_reg[0] * sb4_reg[2];
        pr5_reg[7] <= sa4_reg[0] * sb4_reg[1];
        pr5_reg[8] <= sa4_reg[1] * sb4_reg[0];
        for (int i = 0; i < 3; i++)
        begin
            tc5_reg[i] <= (T_W'(hn4_reg[i]) <<< LO_W) + T_W'(ln4_reg[i]);
        end
    end

    // Stage 6: dot product and cross product shifted down by 30, sign of the
    // triple product.
    always_comb
    begin
        tsum_c = tc5_reg[0] + tc5_reg[1] + tc5_reg[2];
        dot_c  = DOT_W'(pr5_reg[0]) + DOT_W'(pr5_reg[1]) + DOT_W'(pr5_reg[2]);
        dmag_c = dot_c[DOT_W-1] ? DOT_W'(-dot_c) : DOT_W'(dot_c);
        dsh_c  = C_W'(dmag_c >> SHIFT30);
        for (int i = 0; i < 3; i++)
        begin
            crs_c[i]  = CP_W'(pr5_reg[3+2*i]) - CP_W'(pr5_reg[4+2*i]);
            cmag_c[i] = crs_c[i][CP_W-1] ? CP_W'(-crs_c[i]) : CP_W'(crs_c[i]);
            csh_c[i]  = CX_W'(cmag_c[i] >> SHIFT30);
        end
    end

    always_ff @(posedge clk)
    begin
        c6_reg <= dot_c[DOT_W-1] ? -$signed(dsh_c) : $signed(dsh_c);
        for (int i = 0; i < 3; i++)
        begin
            cx6_reg[i] <= crs_c[i][CP_W-1] ? -$signed(csh_c[i]) : $signed(csh_c[i]);
        end
    end

    // Stage 7: squares of the cross components.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_c[i] = cx6_reg[i] * cx6_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        c7_reg <= c6_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq7_reg[i] <= sq_c[i][SQ_W-1:0];
        end
    end

    // Stage 8: squared length of the cross product.
    always_ff @(posedge clk)
    begin
        c8_reg <= c7_reg;
        q8_reg <= Q_W'(sq7_reg[0]) + Q_W'(sq7_reg[1]) + Q_W'(sq7_reg[2]);
    end

    // Sine term: length of the cross product.
    tpad_isqrt u_isqrt (
        .clk  (clk),
        .q    (q8_reg),
        .root (root)
    );

    // Cosine term waits beside the square root.
    always_ff @(posedge clk)
    begin
        cdly_reg[0] <= c8_reg;
        for (int k = 1; k < SQRT_LAT; k++)
        begin
            cdly_reg[k] <= cdly_reg[k-1];
        end
    end

    tpad_cordic u_cordic (
        .clk (clk),
        .c   (cdly_reg[SQRT_LAT-1]),
        .s   (root),
        .acc (acc)
    );

    // The triple product sign joins the control where its item arrives.
    always_comb
    begin
        mneg_c     = mpipe_reg[NEG_AT-1];
        mneg_c.neg = tsum_c[T_W-1];
    end

    // Valid, status and triple product sign travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MP_LEN; k++)
            begin
                mpipe_reg[k] <= '0;
            end
        end
        else
        begin
            mpipe_reg[0] <= meta2_c;
            for (int k = 1; k < MP_LEN; k++)
            begin
                if (k == NEG_AT)
                begin
                    mpipe_reg[k] <= mneg_c;
                end
                else
                begin
                    mpipe_reg[k] <= mpipe_reg[k-1];
                end
            end
        end
    end

    // Output stage: clamp, round to output units, apply the mode.
    assign mout_c = mpipe_reg[MP_LEN-1];

    always_comb
    begin
        if (acc < 0)
        begin
            clamp_c = '0;
        end
        else if (acc > ACC_HALF)
        begin
            clamp_c = ACC_HALF;
        end
        else
        begin
            clamp_c = acc;
        end
        base_c = (clamp_c + RND) >>> RSH;
        res_c  = '0;
        unique case (mout_c.status)
            STATUS_MISSING, STATUS_BOTH_ZERO:
            begin
                res_c = '0;
            end
            STATUS_ONE_ZERO:
            begin
                res_c = RIGHT_ANGLE;
            end
            STATUS_OK:
            begin
                if (mode_reg == MODE_MINIMAL || !mout_c.neg)
                begin
                    res_c = RES_W'(base_c);
                end
                else if (mode_reg == MODE_POSITIVE)
                begin
                    res_c = FULL_TURN - RES_W'(base_c);
                end
                else if (mode_reg == MODE_SIGNED)
                begin
                    res_c = -RES_W'(base_c);
                end
                else
                begin
                    res_c = '0;
                end
            end
            default:
            begin
                res_c = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= mout_c.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg  <= res_c[ANGLE_W-1:0];
        status_reg <= mout_c.status;
    end

    assign done   = done_reg;
    assign angle  = angle_reg;
    assign status = status_reg;

endmodule

`default_nettype wire

@@ rtl/core/tpad_checker.sv @@
// Port-level checks of the three point angle core and their binding.
`default_nettype none

module tpad_checker #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               start,
    input wire logic                               busy,
    input wire logic                               done,
    input wire logic signed [tpad_pkg::ANGLE_W-1:0] angle,
    input wire logic [1:0]                         status
);
    import tpad_pkg::*;

    localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE =
        ANGLE_W'(90) <<< ANGLE_FRAC_BITS;

    // Every result comes from an item accepted the full pipeline depth earlier.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without an item accepted at the pipeline depth");

    // Missing points and two zero legs give a zero angle.
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_MISSING || status == STATUS_BOTH_ZERO))
        |-> (angle == '0))
        else $error("nonzero angle with a degenerate status");

    // One zero leg gives a right angle.
    a_right_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_ONE_ZERO) |-> (angle == RIGHT_ANGLE))
        else $error("one zero leg did not give 90 degrees");

endmodule

bind three_point_angle_degrees_core tpad_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_tpad_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .angle  (angle),
    .status (status)
);

`default_nettype wire
